// File: design/sstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstk_pkg
// Shared codes and types for the set-of-stacks store.
// ----------------------------------------------------------------------------
package sstk_pkg;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int CAP_W    = 7;
    localparam int REPORT_W = 7;
    // width of (stack_index + 1) * capacity
    localparam int PROD_W   = 14;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_AT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd4;

    typedef struct packed {
        logic load_lower;   // take neighbor toward the top (push)
        logic load_upper;   // take neighbor toward the bottom (removal)
    } cell_ctrl_t;

endpackage

// File: design/stack_set_with_pop_at.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_set_with_pop_at
// Bounded value store split into sub-stacks, with push, pop and pop-at.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries action, push_value and
//   stack_index. Output channel (out_valid / out_stall) returns one result
//   per transaction: status, top_valid, top_value, element_count and
//   stack_count, all describing the store after the operation.
//   Values sit in a row of cells with the newest value in cell 0; a push
//   shifts the row down, a pop or pop-at shifts the cells past the removal
//   point up by one. The result is registered on accept; throughput is one
//   transaction per cycle while the receiver keeps up and no recount runs.
//   cfg_write_en loads stack_capacity (0 acts as 1). The sub-stack count
//   and fill are then rebuilt by a bit-serial divider; in_stall is high
//   after the write until the rebuilt counts are loaded.
//   Reset empties the store and sets capacity to 4.
//   While out_stall is high with a result pending, the result register
//   holds and in_stall rises.
// ----------------------------------------------------------------------------
module stack_set_with_pop_at
    import sstk_pkg::*;
#(
    parameter int TOTAL_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [CAP_W-1:0]    cfg_write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [VALUE_W-1:0]  push_value,
    input  logic [INDEX_W-1:0]  stack_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                top_valid,
    output logic [VALUE_W-1:0]  top_value,
    output logic [REPORT_W-1:0] element_count,
    output logic [REPORT_W-1:0] stack_count
);

    localparam int CW = $clog2(TOTAL_DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CAP_W-1:0]    cap_reg;
    logic [CW-1:0]       held_reg,  held_next;
    logic [CW-1:0]       open_reg,  open_next;
    logic [CAP_W-1:0]    fill_reg,  fill_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg,  status_next;
    logic                top_valid_reg;
    logic [VALUE_W-1:0]  top_value_reg, top_value_next;
    logic [REPORT_W-1:0] element_count_reg;
    logic [REPORT_W-1:0] stack_count_reg;

    logic [CAP_W-1:0]    cap_eff;
    logic                accept;
    logic                do_push;
    logic                do_remove;
    logic [CW-1:0]       remove_pos;   // cell index counted from the newest
    logic [PROD_W-1:0]   stack_end;
    logic                div_busy;
    logic                div_done;
    logic [CW-1:0]       div_quo;
    logic [CAP_W-1:0]    div_rem;

    logic [VALUE_W-1:0]  cell_value [TOTAL_DEPTH];
    cell_ctrl_t          cell_ctrl  [TOTAL_DEPTH];

    assign cap_eff  = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign in_stall = div_busy || div_done || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // end of the chosen sub-stack, oldest-first count
    assign stack_end = PROD_W'(PROD_W'(stack_index) + PROD_W'(1)) * PROD_W'(cap_eff);

    always_comb
    begin
        do_push     = 1'b0;
        do_remove   = 1'b0;
        remove_pos  = '0;
        status_next = ST_OK;
        case (action)
            ACT_PUSH:
            begin
                if (held_reg >= CW'(TOTAL_DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push = accept;
                end
            end
            ACT_POP:
            begin
                if (held_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_remove = accept;
                end
            end
            ACT_POP_AT:
            begin
                if (XW'(stack_index) >= XW'(open_reg))
                begin
                    status_next = ST_BAD_INDEX;
                end
                else
                begin
                    do_remove = accept;
                    if (PROD_W'(held_reg) > stack_end)
                    begin
                        remove_pos = CW'(PROD_W'(held_reg) - stack_end);
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // counts: incremental on push/pop, rebuilt by the divider after config
    always_comb
    begin
        held_next = held_reg;
        open_next = open_reg;
        fill_next = fill_reg;
        if (div_done)
        begin
            if (held_reg != '0)
            begin
                open_next = div_quo + 1'b1;
                fill_next = div_rem + 1'b1;
            end
            else
            begin
                open_next = '0;
                fill_next = '0;
            end
        end
        else if (do_push)
        begin
            held_next = held_reg + 1'b1;
            if (held_reg == '0)
            begin
                open_next = CW'(1);
                fill_next = CAP_W'(1);
            end
            else if (fill_reg >= cap_eff)
            begin
                open_next = open_reg + 1'b1;
                fill_next = CAP_W'(1);
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (do_remove)
        begin
            held_next = held_reg - 1'b1;
            if (held_reg == CW'(1))
            begin
                open_next = '0;
                fill_next = '0;
            end
            else if (fill_reg == CAP_W'(1))
            begin
                open_next = open_reg - 1'b1;
                fill_next = cap_eff;
            end
            else
            begin
                fill_next = fill_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        top_value_next = cell_value[0];
        if (do_push)
        begin
            top_value_next = push_value;
        end
        else if (do_remove && remove_pos == '0)
        begin
            top_value_next = cell_value[1];
        end
        if (held_next == '0)
        begin
            top_value_next = '0;
        end
    end

    sstk_recount #(
        .NUM_W (CW),
        .DIV_W (CAP_W)
    ) u_recount (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_write_en),
        .numerator (held_reg - 1'b1),
        .divisor   (cap_eff),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    genvar i;
    generate
        for (i = 0; i < TOTAL_DEPTH; i++)
        begin : g_cell
            logic [VALUE_W-1:0] lower_value;
            logic [VALUE_W-1:0] upper_value;

            if (i == 0)
            begin : g_first
                assign lower_value = push_value;
            end
            else
            begin : g_mid
                assign lower_value = cell_value[i-1];
            end

            if (i == TOTAL_DEPTH - 1)
            begin : g_last
                assign upper_value = cell_value[i];
            end
            else
            begin : g_inner
                assign upper_value = cell_value[i+1];
            end

            assign cell_ctrl[i].load_lower = do_push;
            assign cell_ctrl[i].load_upper = do_remove && (CW'(i) >= remove_pos);

            sstk_cell u_cell (
                .clk         (clk),
                .ctrl        (cell_ctrl[i]),
                .lower_value (lower_value),
                .upper_value (upper_value),
                .value       (cell_value[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            held_reg      <= '0;
            open_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            held_reg <= held_next;
            open_reg <= open_next;
            fill_reg <= fill_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            top_valid_reg     <= (held_next != '0);
            top_value_reg     <= top_value_next;
            element_count_reg <= REPORT_W'(held_next);
            stack_count_reg   <= REPORT_W'(open_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign top_valid     = top_valid_reg;
    assign top_value     = top_value_reg;
    assign element_count = element_count_reg;
    assign stack_count   = stack_count_reg;

endmodule

// File: design/sstk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstk_cell
// One value cell of the store; loads from either neighbor or holds.
// ----------------------------------------------------------------------------
module sstk_cell
    import sstk_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [VALUE_W-1:0] lower_value,
    input  logic [VALUE_W-1:0] upper_value,
    output logic [VALUE_W-1:0] value
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load_lower)
        begin
            value_next = lower_value;
        end
        else if (ctrl.load_upper)
        begin
            value_next = upper_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: design/sstk_recount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstk_recount
// Restoring divider, one quotient bit per cycle, used to rebuild the
// sub-stack count and fill after a capacity change.
// ----------------------------------------------------------------------------
module sstk_recount #(
    parameter int NUM_W = 7,
    parameter int DIV_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] num_reg,  num_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            num_next = numerator;
            quo_next = '0;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = num_reg << 1;
            quo_next = {quo_reg[NUM_W-2:0], fits};
            // remainder stays below divisor, so DIV_W bits hold it
            rem_next = fits ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: bench/tb_stack_set_with_pop_at.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_set_with_pop_at
// Self-checking bench for the set-of-stacks store. A tracker class keeps its
// own copy of the cells, counts and capacity and predicts the report of each
// accepted transaction. Reports are checked in order, field by field. A short
// directed run is followed by random bursts (fill, drain, mixed) over several
// capacity settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_stack_set_with_pop_at;
    import sstk_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTED = 10;

    // action code with no operation behind it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                top_valid;
        logic [VALUE_W-1:0]  top_value;
        logic [REPORT_W-1:0] element_count;
        logic [REPORT_W-1:0] stack_count;
    } store_report_t;

    class substack_tracker;
        logic [VALUE_W-1:0] cells [STORE_DEPTH];
        int unsigned held;
        int unsigned open_stk;
        int unsigned last_fill;
        logic [CAP_W-1:0] capacity;
        store_report_t pending_reports [$];
        int unsigned mismatches;

        function new();
            held = 0;
            open_stk = 0;
            last_fill = 0;
            capacity = CAP_RESET;
            mismatches = 0;
            foreach (cells[i])
                cells[i] = '0;
        endfunction

        function int unsigned eff_capacity();
            return (capacity == 0) ? 1 : int'(capacity);
        endfunction

        function void regroup();
            int unsigned cap;
            cap = eff_capacity();
            if (held == 0)
            begin
                open_stk = 0;
                last_fill = 0;
            end
            else
            begin
                open_stk = (held + cap - 1) / cap;
                last_fill = held - (open_stk - 1) * cap;
            end
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
            regroup();
        endfunction

        // later values move one cell toward the front
        function void drop_cell(int unsigned pos);
            for (int unsigned i = pos; i + 1 < held; i++)
                cells[i] = cells[i + 1];
            held--;
            regroup();
        endfunction

        function void record_op(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val,
                                logic [INDEX_W-1:0] idx);
            store_report_t rep;
            int unsigned stop;
            rep.status = ST_OK;
            case (act)
                ACT_PUSH:
                begin
                    if (held >= STORE_DEPTH)
                        rep.status = ST_FULL;
                    else
                    begin
                        cells[held] = val;
                        held++;
                        regroup();
                    end
                end
                ACT_POP:
                begin
                    if (held == 0)
                        rep.status = ST_EMPTY;
                    else
                        drop_cell(held - 1);
                end
                ACT_POP_AT:
                begin
                    if (idx >= open_stk)
                        rep.status = ST_BAD_INDEX;
                    else
                    begin
                        stop = (idx + 1) * eff_capacity();
                        if (stop > held)
                            stop = held;
                        drop_cell(stop - 1);
                    end
                end
                default: ;
            endcase
            rep.top_valid = (held > 0);
            rep.top_value = (held > 0) ? cells[held - 1] : '0;
            rep.element_count = REPORT_W'(held);
            rep.stack_count = REPORT_W'(open_stk);
            pending_reports.push_back(rep);
        endfunction

        function void compare_report(logic [STATUS_W-1:0] st, logic tv, logic [VALUE_W-1:0] top,
                                     logic [REPORT_W-1:0] elems, logic [REPORT_W-1:0] stacks);
            store_report_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("%0t: report with no transaction pending: status %0d top %h",
                             $realtime, st, top);
                return;
            end
            want = pending_reports.pop_front();
            if (st !== want.status || tv !== want.top_valid || top !== want.top_value ||
                elems !== want.element_count || stacks !== want.stack_count)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                begin
                    $write("%0t: mismatch (exp/got) status %0d/%0d top_valid %0b/%0b ",
                           $realtime, want.status, st, want.top_valid, tv);
                    $display("top %h/%h count %0d/%0d stacks %0d/%0d",
                             want.top_value, top, want.element_count, elems,
                             want.stack_count, stacks);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [CAP_W-1:0]    cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = ACT_PUSH;
    logic [VALUE_W-1:0]  push_value = '0;
    logic [INDEX_W-1:0]  stack_index = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                top_valid;
    logic [VALUE_W-1:0]  top_value;
    logic [REPORT_W-1:0] element_count;
    logic [REPORT_W-1:0] stack_count;

    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;
    substack_tracker tracker;

    stack_set_with_pop_at #(
        .TOTAL_DEPTH(STORE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .push_value(push_value),
        .stack_index(stack_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .top_valid(top_valid),
        .top_value(top_value),
        .element_count(element_count),
        .stack_count(stack_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_report(status, top_valid, top_value, element_count, stack_count);
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one transaction and hold it until accepted
    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        push_value <= val;
        stack_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.record_op(act, val, idx);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_reports.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_write_en <= 1'b1;
        cfg_write_data <= cap;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tracker.set_capacity(cap);
    endtask

    function automatic void choose_op(input int unsigned mode, output logic [ACTION_W-1:0] act,
                                      output logic [VALUE_W-1:0] val,
                                      output logic [INDEX_W-1:0] idx);
        int unsigned roll;
        int unsigned push_w;
        int unsigned pop_w;
        int unsigned unused_w;
        case (mode)
            MODE_FILL:  begin push_w = 80; pop_w = 8;  unused_w = 2; end
            MODE_DRAIN: begin push_w = 15; pop_w = 40; unused_w = 2; end
            default:    begin push_w = 45; pop_w = 25; unused_w = 3; end
        endcase
        roll = $urandom_range(99);
        if (roll < push_w)
            act = ACT_PUSH;
        else if (roll < push_w + pop_w)
            act = ACT_POP;
        else if (roll < 100 - unused_w)
            act = ACT_POP_AT;
        else
            act = ACT_UNUSED;

        case ($urandom_range(15))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = 32'h0000_0000;
            3: val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase

        // mostly aim at an open sub-stack, sometimes anywhere
        if (tracker.open_stk != 0 && $urandom_range(4) != 0)
            idx = INDEX_W'($urandom_range(tracker.open_stk - 1, 0));
        else
            idx = INDEX_W'($urandom_range(63, 0));
    endfunction

    initial
    begin : stimulus
        logic [CAP_W-1:0] cap_plan [NUM_PHASES];
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
        int unsigned burst_left;
        int unsigned mode;

        tracker = new();
        cap_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd7, 7'd4, 7'd4};
        cap_plan[7] = CAP_W'($urandom_range(63, 2));
        mode = MODE_MIXED;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed run at the reset capacity of four
        send_op(ACT_POP,    '0, '0);
        send_op(ACT_POP_AT, '0, 6'd0);
        send_op(ACT_POP_AT, '0, 6'd63);
        send_op(ACT_UNUSED, 32'h1234_5678, 6'd0);
        send_op(ACT_PUSH,   32'h7FFF_FFFF, '0);
        send_op(ACT_PUSH,   32'h8000_0000, 6'd63);
        send_op(ACT_PUSH,   32'h0000_0000, '0);
        send_op(ACT_PUSH,   32'hFFFF_FFFF, '0);
        send_op(ACT_PUSH,   32'd1, '0);
        send_op(ACT_PUSH,   32'd2, '0);
        send_op(ACT_PUSH,   32'd3, '0);
        send_op(ACT_PUSH,   32'd4, '0);
        send_op(ACT_PUSH,   32'd5, '0);
        send_op(ACT_POP_AT, '0, 6'd0);
        send_op(ACT_POP_AT, '0, 6'd2);
        send_op(ACT_POP_AT, '0, 6'd1);
        send_op(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_op(ACT_POP,    '0, '0);
        send_op(ACT_POP_AT, '0, 6'd0);
        send_op(ACT_PUSH,   32'hAAAA_AAAA, '0);
        send_op(ACT_PUSH,   32'h5555_5555, '0);
        send_op(ACT_POP_AT, '0, 6'd63);
        send_op(ACT_POP_AT, 32'hFFFF_FFFF, 6'd1);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            repeat (2) @(posedge clk);
            write_capacity(cap_plan[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 66; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 66; end
                default: begin sender_idle_pct = 12; stall_pct = 12; end
            endcase
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (burst_left == 0)
                begin
                    mode = $urandom_range(MODE_MIXED, MODE_FILL);
                    burst_left = $urandom_range(80, 10);
                end
                burst_left--;
                choose_op(mode, act, val, idx);
                send_op(act, val, idx);
                // occasional full pause of the sender mid-phase
                if ($urandom_range(149) == 0)
                    wait_for_drain();
            end
        end

        wait_for_drain();
        stall_pct = 0;
        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
